### hdl/decimal_string_to_integer_assert.svh
// assertion macros for the decimal string to integer block
// used by modules that check their own control logic; needs clk_i and rst_ni in scope
`ifndef DECIMAL_STRING_TO_INTEGER_ASSERT_SVH
`define DECIMAL_STRING_TO_INTEGER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DSTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dsti_pkg.sv
// shared types and constants of the decimal string to integer block
// no dependencies
`default_nettype none

package dsti_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned POS_W = 10;
  localparam int unsigned DIG_W = 5;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [DIG_W-1:0] MAX_DIG_WIDE   = 5'd19;
  localparam logic [DIG_W-1:0] MAX_DIG_NARROW = 5'd9;

  localparam logic [VAL_W-1:0] MAX64     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] MIN64     = 64'h8000_0000_0000_0000;
  localparam logic [VAL_W-1:0] MAX32_EXT = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VAL_W-1:0] MIN32_EXT = 64'hFFFF_FFFF_8000_0000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BLANK    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HEAD  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_DIGIT = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [VAL_W-1:0]  value;
    logic [POS_W-1:0]  pos;
  } res_t;

endpackage

`default_nettype wire

### hdl/dsti_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dsti_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/dsti_core.sv
// string store control and backward digit scan of the decimal string to integer block
// depends on dsti_pkg, dsti_ram and decimal_string_to_integer_assert.svh
`default_nettype none
`include "decimal_string_to_integer_assert.svh"

module dsti_core #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wide_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_char_i,
  input  logic          in_end_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output dsti_pkg::res_t res_o
);
  import dsti_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                overlong_q, overlong_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;
  logic                neg_q, neg_d;
  logic [VAL_W-1:0]    mag_q, mag_d;
  logic [VAL_W-1:0]    place_q, place_d;
  logic [VAL_W-1:0]    add_q, add_d;
  logic [DIG_W-1:0]    digits_q, digits_d;
  res_t                res_q, res_d;

  logic                in_acc;
  logic                wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;
  logic                is_digit;
  logic [3:0]          dig;
  logic [DIG_W-1:0]    digits_inc;
  logic [DIG_W-1:0]    max_dig;
  logic                at_begin;
  logic [VAL_W-1:0]    sum;
  logic [VAL_W-1:0]    lim;
  logic [VAL_W-1:0]    sat_val;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && !in_end_i && (count_q < CNT_W'(MAX_LEN));
  // address 0 stays on the read port while idle, so the sign byte is ready in the head state
  assign rd_addr    = (state_q == S_READ) ? idx_q : '0;

  dsti_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (in_char_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign is_digit   = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
  assign dig        = 4'(rd_data - CH_ZERO);
  assign digits_inc = digits_q + DIG_W'(1);
  assign max_dig    = wide_i ? MAX_DIG_WIDE : MAX_DIG_NARROW;
  assign at_begin   = (idx_q == ADDR_W'(neg_q));
  assign sum        = mag_q + add_q;
  assign lim        = neg_q ? MIN64 : MAX64;
  assign sat_val    = wide_i ? (neg_q ? MIN64 : MAX64) : (neg_q ? MIN32_EXT : MAX32_EXT);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    overlong_d = overlong_q;
    idx_d      = idx_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    place_d    = place_q;
    add_d      = add_q;
    digits_d   = digits_q;
    res_d      = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_end_i) begin
            if (count_q < CNT_W'(MAX_LEN)) begin
              count_d = count_q + CNT_W'(1);
            end else begin
              overlong_d = 1'b1;
            end
          end else begin
            mag_d    = '0;
            place_d  = VAL_W'(1);
            digits_d = '0;
            if (overlong_q) begin
              res_d   = '{status: ST_TOO_LONG, value: '0, pos: '0};
              state_d = S_EMIT;
            end else if (count_q == '0) begin
              res_d   = '{status: ST_BLANK, value: '0, pos: '0};
              state_d = S_EMIT;
            end else begin
              state_d = S_HEAD;
            end
          end
        end
      end
      S_HEAD: begin
        neg_d = (rd_data == CH_MINUS);
        if ((rd_data == CH_MINUS) && (count_q == CNT_W'(1))) begin
          res_d   = '{status: ST_BLANK, value: '0, pos: POS_W'(1)};
          state_d = S_EMIT;
        end else begin
          idx_d   = ADDR_W'(count_q - CNT_W'(1));
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_DIGIT;
      end
      S_DIGIT: begin
        if (is_digit) begin
          if (digits_inc > max_dig) begin
            // surplus digit: position is the string length
            res_d   = '{status: ST_OVERFLOW, value: sat_val, pos: POS_W'(count_q)};
            state_d = S_EMIT;
          end else begin
            digits_d = digits_inc;
            add_d    = place_q * VAL_W'(dig);
            state_d  = S_ACC;
          end
        end else if (at_begin) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q - ADDR_W'(1);
          state_d = S_READ;
        end
      end
      S_ACC: begin
        if (wide_i && (sum > lim)) begin
          // out of range: index of this digit minus one, may wrap to all ones
          res_d   = '{status: ST_OVERFLOW, value: sat_val,
                      pos: POS_W'(idx_q) - POS_W'(1)};
          state_d = S_EMIT;
        end else begin
          mag_d   = sum;
          place_d = (place_q << 3) + (place_q << 1);
          if (at_begin) begin
            state_d = S_FIN;
          end else begin
            idx_d   = idx_q - ADDR_W'(1);
            state_d = S_READ;
          end
        end
      end
      S_FIN: begin
        if (digits_q == '0) begin
          res_d = '{status: ST_BLANK, value: '0, pos: '0};
        end else begin
          res_d = '{status: ST_OK, value: (neg_q ? (VAL_W'(0) - mag_q) : mag_q), pos: '0};
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          count_d    = '0;
          overlong_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      overlong_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      overlong_q <= overlong_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    place_q  <= place_d;
    add_q    <= add_d;
    digits_q <= digits_d;
    res_q    <= res_d;
  end

  assign res_valid_o = (state_q == S_EMIT);
  assign res_o       = res_q;

  `DSTI_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_LEN), "char count past store depth")
  `DSTI_ASSERT_NEXT(a_end_starts, in_acc && in_end_i, (state_q == S_HEAD) || (state_q == S_EMIT), "end request did not start a parse")
  `DSTI_ASSERT_IMP(a_read_in_string, state_q == S_READ, CNT_W'(idx_q) < count_q, "scan index outside stored string")
  `DSTI_ASSERT_IMP(a_place_live, state_q == S_ACC, place_q != '0, "place value collapsed to zero")

endmodule

`default_nettype wire

### hdl/decimal_string_to_integer.sv
// scan: a character request is stored as it is taken; an end request goes through a head
//   state for the sign byte, then per stored byte a read and a digit state (non-digit) or
//   read, digit and accumulate states (digit), finish and handoff states, the output register
// throughput: one character per cycle; the end request holds input until the result is taken,
//   the scan rate is set by the single read port of the string ram and the digit add
// reset: count, too-long flag and output valid clear, width_mode returns to 64-bit;
//   the string ram is not cleared and needs no clearing pass
`default_nettype none

module decimal_string_to_integer #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // is_end
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [63:0] parsed_value, [73:64] error_position, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // width_mode register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // width_mode
);
  import dsti_pkg::*;

  logic        wide_q;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  logic        out_valid_q;
  logic [79:0] out_data_q;
  logic [1:0]  out_user_q;

  // register writes are taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wide_q <= cfg_data_i;
    end
  end

  // store and scan engine
  dsti_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wide_i      (wide_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: the core hands over when the slot is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {6'b0, res.pos, res.value};
      out_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### tb/sv/decimal_string_to_integer_tb.sv
// self-checking testbench for the decimal string to integer block: character
// strings in, signed parse results out, checked against an in-bench parser
// depends on dsti_pkg and decimal_string_to_integer
`default_nettype none

module decimal_string_to_integer_tb;
  import dsti_pkg::*;

  localparam int unsigned STR_MAX = 256;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  decimal_string_to_integer #(
    .MAX_LEN(STR_MAX)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // stimulus and prediction state
  char_item_t  pending_chars_q[$];
  logic [7:0]  str_q[$];          // line under construction
  logic [7:0]  line_q[$];         // characters the block has taken for the current line
  logic        line_overlong = 1'b0;
  logic        wide_mode = 1'b1;  // 64-bit after reset
  res_t        want_parse_q[$];
  logic        in_took = 1'b0;

  // bookkeeping
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned chars_sent = 0;
  int unsigned stat_cnt[4] = '{0, 0, 0, 0};
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned long_cnt = 0;
  logic        calm;

  // stretch with no idling on either side, inside the first directed pass
  assign calm = (chars_sent >= 400) && (chars_sent < 550);

  function automatic logic [63:0] sat_limit(input logic neg, input logic wide);
    if (wide) return neg ? MIN64 : MAX64;
    return neg ? MIN32_EXT : MAX32_EXT;
  endfunction

  // parse of line_q as the block must do it: backward scan with place values
  function automatic res_t parse_decimal(input logic too_long, input logic wide);
    res_t            r;
    int              n;
    int              first_idx;
    int              digs;
    int              max_digs;
    logic            neg;
    logic            done;
    logic [7:0]      c;
    longint unsigned mag;
    longint unsigned place;
    longint unsigned add;
    longint unsigned lim;
    r.status = ST_OK;
    r.value  = '0;
    r.pos    = '0;
    n = line_q.size();
    if (too_long) begin
      r.status = ST_TOO_LONG;
    end else if (n == 0) begin
      r.status = ST_BLANK;
    end else begin
      neg = (line_q[0] == CH_MINUS);
      first_idx = neg ? 1 : 0;
      if (neg && n == 1) begin
        r.status = ST_BLANK;
        r.pos    = POS_W'(1);
      end else begin
        mag = 0;
        place = 1;
        digs = 0;
        done = 1'b0;
        max_digs = wide ? 19 : 9;
        lim = neg ? MIN64 : MAX64;
        for (int i = n - 1; i >= first_idx && !done; i--) begin
          c = line_q[i];
          if (c >= CH_ZERO && c <= CH_NINE) begin
            digs++;
            add = 64'(c - CH_ZERO) * place;
            if (digs > max_digs) begin
              // surplus digit: position is the string length
              r.status = ST_OVERFLOW;
              r.value  = sat_limit(neg, wide);
              r.pos    = POS_W'(n);
              done = 1'b1;
            end else if (wide && (mag + add > lim)) begin
              // out of 64-bit range: digit index minus one, may go negative
              r.status = ST_OVERFLOW;
              r.value  = sat_limit(neg, wide);
              r.pos    = POS_W'(i - 1);
              done = 1'b1;
            end else begin
              mag += add;
              place *= 10;
            end
          end
        end
        if (!done) begin
          if (digs == 0) begin
            r.status = ST_BLANK;
          end else begin
            r.value = neg ? (64'd0 - mag) : mag;
          end
        end
      end
    end
    return r;
  endfunction

  // input side: capture accepted requests and predict the parse on the end request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      in_took = 1'b1;
      if (s_axis_tlast) begin
        want_parse_q.push_back(parse_decimal(line_overlong, wide_mode));
        line_q.delete();
        line_overlong = 1'b0;
      end else begin
        chars_sent++;
        if (line_q.size() < STR_MAX) line_q.push_back(s_axis_tdata);
        else line_overlong = 1'b1;
      end
    end
  end

  // driver: next request on the falling edge once the current one is taken
  always @(negedge clk_i) begin
    char_item_t it;
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      in_took = 1'b0;
      if (pending_chars_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
        it = pending_chars_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.ch;
        s_axis_tlast  <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure, with one long hold-off while the sender still has work
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 5 && pending_chars_q.size() > 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // monitor: compare each result with the oldest predicted parse
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser);
      got.value  = m_axis_tdata[63:0];
      got.pos    = m_axis_tdata[73:64];
      results_seen++;
      stat_cnt[m_axis_tuser]++;
      if (want_parse_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: result with nothing expected: status %0d value %0d pos %0d",
                   got.status, $signed(got.value), $signed(got.pos));
      end else begin
        want = want_parse_q.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.pos !== want.pos) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: result %0d: status %0d/%0d value %0d/%0d pos %0d/%0d (exp/got)",
                     results_seen, want.status, got.status, $signed(want.value),
                     $signed(got.value), $signed(want.pos), $signed(got.pos));
        end
      end
    end
  end

  // line building helpers
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c >= CH_ZERO && c <= CH_NINE) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] digit_byte();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  task automatic put_text(input string t);
    for (int i = 0; i < t.len(); i++) str_q.push_back(t[i]);
  endtask

  // move the built line to the driver queue, closed by an end request
  task automatic queue_line();
    char_item_t it;
    foreach (str_q[i]) begin
      it.ch = str_q[i];
      it.last = 1'b0;
      pending_chars_q.push_back(it);
    end
    it.ch = 8'($urandom_range(255));
    it.last = 1'b1;
    pending_chars_q.push_back(it);
    str_q.delete();
  endtask

  task automatic directed_lines(input logic with_long);
    put_text("");                     queue_line();  // empty
    put_text("-");                    queue_line();  // lone minus
    put_text("abc");                  queue_line();  // no digits
    put_text("0");                    queue_line();
    put_text("-0");                   queue_line();
    put_text("12345");                queue_line();
    put_text("-999999999");           queue_line();
    put_text("2147483647");           queue_line();  // ten digits
    put_text("-2147483648");          queue_line();
    put_text("9223372036854775807");  queue_line();  // 64-bit limits
    put_text("-9223372036854775808"); queue_line();
    put_text("9223372036854775808");  queue_line();  // range broken at first digit
    put_text("-9223372036854775809"); queue_line();
    put_text("99999999999999999999"); queue_line();  // twenty digits
    put_text("0000000000000000000001"); queue_line();
    put_text("-x7");                  queue_line();
    put_text("7-");                   queue_line();
    put_text(" 42 ");                 queue_line();
    // zero byte in the middle is skipped, not a terminator
    put_text("1"); str_q.push_back(8'h00); put_text(" 2"); queue_line();
    str_q.push_back(8'hFF); put_text("5"); str_q.push_back(8'h80); queue_line();
    if (with_long) begin
      // exactly full store
      str_q.push_back(CH_MINUS);
      repeat (STR_MAX - 3) str_q.push_back(noise_byte());
      put_text("77");
      queue_line();
      // one character more than the store holds
      repeat (STR_MAX + 1) str_q.push_back(digit_byte());
      queue_line();
    end
    put_text("31");                   queue_line();  // store state cleared after too long
  endtask

  task automatic random_lines(input int unsigned n_items);
    int unsigned added;
    int unsigned kind;
    int unsigned ndig;
    int unsigned base;
    logic        noisy;
    added = 0;
    while (added < n_items) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        // well-formed number, sometimes with noise between digits
        if ($urandom_range(19) == 0) str_q.push_back(noise_byte());
        if ($urandom_range(1)) str_q.push_back(CH_MINUS);
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: ndig = $urandom_range(9, 1);
          6:                ndig = $urandom_range(12, 10);
          7:                ndig = $urandom_range(21, 18);
          default:          ndig = $urandom_range(25, 1);
        endcase
        noisy = ($urandom_range(9) < 3);
        repeat (ndig) begin
          if (noisy && $urandom_range(6) == 0) str_q.push_back(noise_byte());
          str_q.push_back(digit_byte());
        end
      end else if (kind < 55) begin
        // nineteen digits near the 64-bit limit
        if ($urandom_range(1)) str_q.push_back(CH_MINUS);
        base = str_q.size();
        if ($urandom_range(1)) put_text("9223372036854775807");
        else put_text("9223372036854775808");
        case ($urandom_range(3))
          1: str_q[base + $urandom_range(18)] = digit_byte();
          2: for (int i = 1; i < 19; i++) str_q[base + i] = digit_byte();
          3: str_q[base + 18] = str_q[base + 18] + 8'd1;
          default: ;
        endcase
      end else if (kind < 65) begin
        // blank forms
        case ($urandom_range(2))
          0: ;
          1: str_q.push_back(CH_MINUS);
          default: begin
            if ($urandom_range(1)) str_q.push_back(CH_MINUS);
            repeat ($urandom_range(8, 1)) str_q.push_back(noise_byte());
          end
        endcase
      end else if (kind < 85) begin
        repeat ($urandom_range(30)) begin
          if ($urandom_range(1)) str_q.push_back(digit_byte());
          else str_q.push_back(8'($urandom_range(255)));
        end
      end else if (kind < 87 && long_cnt < 4) begin
        // long lines around the store size
        long_cnt++;
        repeat ($urandom_range(STR_MAX + 6, STR_MAX - 6)) begin
          if ($urandom_range(9) == 0) str_q.push_back(digit_byte());
          else str_q.push_back(noise_byte());
        end
      end else begin
        if ($urandom_range(1)) str_q.push_back(CH_MINUS);
        repeat ($urandom_range(4, 1)) str_q.push_back(digit_byte());
      end
      added += str_q.size() + 1;
      queue_line();
    end
  endtask

  task automatic write_width(input logic w);
    @(negedge clk_i);
    cfg_data_i  <= w;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    wide_mode = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until every request is taken and every parse has come back
  task automatic drain();
    @(posedge clk_i);
    while (pending_chars_q.size() != 0 || s_axis_tvalid || want_parse_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 64-bit mode straight from reset, with the lines around the store size
    directed_lines(1'b1);
    drain();

    write_width(1'b0);
    directed_lines(1'b0);
    random_lines(120);
    drain();

    write_width(1'b1);
    random_lines(130);
    drain();

    write_width(1'b0);
    random_lines(80);
    drain();

    repeat (30) @(posedge clk_i);
    $display("parsed %0d lines from %0d characters: ok %0d, blank %0d, overflow %0d",
             results_seen, chars_sent, stat_cnt[0], stat_cnt[1], stat_cnt[2]);
    $display("too long %0d, both width modes, a %0d-cycle output hold-off, %0d mismatches",
             stat_cnt[3], HOLD_CYCLES, err_cnt);
    if (err_cnt == 0 && want_parse_q.size() == 0) begin
      $display("decimal_string_to_integer_tb OK");
    end else begin
      $display("decimal_string_to_integer_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d parses outstanding", want_parse_q.size());
    $display("decimal_string_to_integer_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
